// ----- design/u8d_pkg.sv -----
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

  localparam int CpW = 21;
  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

  // command queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  // one classified input byte: replacements first, then an optional final result
  typedef struct packed {
    logic [1:0]     rep_count;
    logic           has_final;
    logic [CpW-1:0] final_cp;
    logic           final_bad;
    logic           eos;
  } cmd_t;

endpackage

// ----- design/utf8_stream_decoder.sv -----
// top level of the lenient utf-8 stream decoder
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------------
//   bytes in | push / full      | data_byte[7:0], end_of_string
//   results  | pop / empty      | code_point[20:0], malformed, last_of_run,
//            |                  | string_done
//
// one byte is taken per cycle while the four-entry command queue has room
// each byte yields zero to four results; the back end delivers one result per cycle while
// its output register is free or being popped, so a byte that breaks a sequence yields up to four results
// a byte's first result passes through the queue entry written when the byte is taken,
// then through the output register
// rst clears the sequence state, the queue and the output valid flag; empty is high after it
// stalls on pop back up through the queue and raise full once four commands wait
module utf8_stream_decoder (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_string,
  output logic                    empty,
  input  logic                    pop,
  output logic [u8d_pkg::CpW-1:0] code_point,
  output logic                    malformed,
  output logic                    last_of_run,
  output logic                    string_done
);
  import u8d_pkg::*;

  logic q_full;
  logic enq;
  cmd_t enq_cmd;
  logic rd_en;
  logic rd_valid;
  cmd_t rd_cmd;

  u8d_front front_i (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .enq           (enq),
    .enq_cmd       (enq_cmd)
  );

  u8d_queue queue_i (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (enq),
    .wr_cmd   (enq_cmd),
    .q_full   (q_full),
    .rd_en    (rd_en),
    .rd_valid (rd_valid),
    .rd_cmd   (rd_cmd)
  );

  u8d_back back_i (
    .clk         (clk),
    .rst         (rst),
    .rd_valid    (rd_valid),
    .rd_cmd      (rd_cmd),
    .rd_en       (rd_en),
    .empty       (empty),
    .pop         (pop),
    .code_point  (code_point),
    .malformed   (malformed),
    .last_of_run (last_of_run),
    .string_done (string_done)
  );

endmodule

// ----- design/u8d_front.sv -----
// front end: sequence tracking and classification of each byte into a command
module u8d_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    data_byte,
  input  logic          end_of_string,
  input  logic          q_full,
  output logic          enq,
  output u8d_pkg::cmd_t enq_cmd
);
  import u8d_pkg::*;

  logic [1:0]     pending_count, pending_count_next;
  logic [2:0]     needed_length, needed_length_next;
  logic [CpW-1:0] partial_value, partial_value_next;

  logic           accept;
  logic           is_cont;
  logic [2:0]     count_inc;
  logic [CpW-1:0] value_inc;
  cmd_t           cmd;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign is_cont = (data_byte[7:6] == 2'b10);
  assign count_inc = {1'b0, pending_count} + 3'd1;
  assign value_inc = {partial_value[CpW-7:0], data_byte[5:0]};

  // classification and next state
  always_comb begin
    cmd = '0;
    cmd.eos = end_of_string;
    pending_count_next = pending_count;
    needed_length_next = needed_length;
    partial_value_next = partial_value;
    if (pending_count != 2'd0 && is_cont) begin
      partial_value_next = value_inc;
      pending_count_next = count_inc[1:0];
      if (count_inc >= needed_length) begin
        cmd.has_final = 1'b1;
        cmd.final_cp  = value_inc;
        pending_count_next = 2'd0;
      end else if (end_of_string) begin
        // string ended inside the sequence: one replacement per buffered byte, this byte included
        cmd.rep_count = count_inc[1:0];
        pending_count_next = 2'd0;
      end
    end else begin
      // broken sequence replays the buffered bytes, then the byte starts afresh
      cmd.rep_count = pending_count;
      pending_count_next = 2'd0;
      priority if (!data_byte[7]) begin
        cmd.has_final = 1'b1;
        cmd.final_cp  = {{(CpW-8){1'b0}}, data_byte};
      end else if (data_byte[7:5] == 3'b110 && !end_of_string) begin
        pending_count_next = 2'd1;
        needed_length_next = 3'd2;
        partial_value_next = {{(CpW-5){1'b0}}, data_byte[4:0]};
      end else if (data_byte[7:4] == 4'b1110 && !end_of_string) begin
        pending_count_next = 2'd1;
        needed_length_next = 3'd3;
        partial_value_next = {{(CpW-4){1'b0}}, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110 && !end_of_string) begin
        pending_count_next = 2'd1;
        needed_length_next = 3'd4;
        partial_value_next = {{(CpW-3){1'b0}}, data_byte[2:0]};
      end else begin
        cmd.has_final = 1'b1;
        cmd.final_cp  = Replacement;
        cmd.final_bad = 1'b1;
      end
    end
    if (end_of_string) begin
      pending_count_next = 2'd0;
    end
  end

  assign enq     = accept && (cmd.has_final || cmd.rep_count != 2'd0);
  assign enq_cmd = cmd;

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      needed_length <= 3'd0;
      partial_value <= '0;
    end else if (accept) begin
      pending_count <= pending_count_next;
      needed_length <= needed_length_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

// ----- design/u8d_queue.sv -----
// short command queue between front and back
module u8d_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  u8d_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd_en,
  output logic          rd_valid,
  output u8d_pkg::cmd_t rd_cmd
);
  import u8d_pkg::*;

  cmd_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign q_full   = (count == QCntW'(QDepth));
  assign rd_valid = (count != '0);
  assign rd_cmd   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + QCntW'(1);
        2'b01:   count <= count - QCntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/u8d_back.sv -----
// back end: expands each command into results, one per cycle while the output register is free or being popped
module u8d_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_valid,
  input  u8d_pkg::cmd_t           rd_cmd,
  output logic                    rd_en,
  output logic                    empty,
  input  logic                    pop,
  output logic [u8d_pkg::CpW-1:0] code_point,
  output logic                    malformed,
  output logic                    last_of_run,
  output logic                    string_done
);
  import u8d_pkg::*;

  logic [1:0]     idx;
  logic           out_valid;
  logic           load;
  logic [2:0]     total;
  logic           is_last;
  logic           in_rep;
  logic [CpW-1:0] cp_sel;
  logic           bad_sel;

  assign total   = {1'b0, rd_cmd.rep_count} + {2'b00, rd_cmd.has_final};
  assign is_last = ({1'b0, idx} + 3'd1 == total);
  assign in_rep  = (idx < rd_cmd.rep_count);
  assign cp_sel  = in_rep ? Replacement : rd_cmd.final_cp;
  assign bad_sel = in_rep ? 1'b1 : rd_cmd.final_bad;

  // a new result moves in when the register is free or being taken
  assign load  = rd_valid && (!out_valid || pop);
  assign rd_en = load && is_last;
  assign empty = !out_valid;

  // result index within the current command, and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      code_point  <= cp_sel;
      malformed   <= bad_sel;
      last_of_run <= is_last;
      string_done <= is_last && rd_cmd.eos;
    end
  end

endmodule

// ----- design/u8d_checker.sv -----
// port-level checks for the utf-8 stream decoder, bound to the top level
module u8d_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    empty,
  input logic                    pop,
  input logic [u8d_pkg::CpW-1:0] code_point,
  input logic                    malformed,
  input logic                    last_of_run,
  input logic                    string_done
);
  import u8d_pkg::*;

  // the final result of a string also closes its byte's run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && string_done) |-> last_of_run)
    else $error("string_done without last_of_run");

  // a replacement result always carries the replacement code point
  a_bad_is_fffd: assert property (@(posedge clk) disable iff (rst)
    (!empty && malformed) |-> (code_point == Replacement))
    else $error("malformed result with wrong code point");

  // only the last result of a byte can be a decoded character
  a_early_is_bad: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last_of_run) |-> malformed)
    else $error("non-final result not marked malformed");

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result present after reset");

  // a waiting result holds until its transaction completes
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(code_point) && $stable(malformed)))
    else $error("waiting result changed");

endmodule

bind utf8_stream_decoder u8d_checker checker_i (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .code_point  (code_point),
  .malformed   (malformed),
  .last_of_run (last_of_run),
  .string_done (string_done)
);
